/* hw/rtl/etbl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// etbl_pkg: shared definitions of the elevation tile lookup
// Register indexes, reset values and fixed constants of the lookup block.
// ----------------------------------------------------------------------------
package etbl_pkg;

    localparam int DEF_MAX_SIDE      = 1201;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SECONDS_PER_PIXEL = 2'd0,
        REG_SIDE_SAMPLES      = 2'd1,
        REG_TILE_LATITUDE     = 2'd2,
        REG_TILE_LONGITUDE    = 2'd3
    } reg_index_t;

    localparam logic [3:0]  SPP_RESET   = 4'd3;
    localparam logic [10:0] SIDE_RESET  = 11'd1201;
    localparam logic [15:0] VOID_WORD   = 16'h8000;
    localparam int          MINUTES_PER_DEG = 60;
    localparam int          ARCSEC_PER_DEG  = MINUTES_PER_DEG * MINUTES_PER_DEG;

endpackage
`default_nettype wire

/* hw/rtl/elevation_tile_bilinear_lookup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elevation_tile_bilinear_lookup: one elevation tile with bilinear lookup
// Stores a square tile of 16-bit samples and answers position queries with
// an interpolated height in metres, signed fixed point with 8 fraction bits.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low. A load word writes
// one sample if its index lies inside the store; it produces no result, and
// busy stays low. A query word that misses the tile (or arrives before the
// last sample of a load) returns hit 0 and height 0 with done in the next
// cycle, again without raising busy. A query that hits keeps busy high while
// it is worked through, and the result shows with done high for exactly one
// cycle; it cannot be held off, so the receiver must take it then. The work
// runs through the shared bit-serial divider, which takes one quotient bit
// per cycle for latitude and then longitude, and through the single memory
// port that reads the four corner samples one after another. Configuration
// writes are taken at any time but are only meant while the block is idle.
// Samples never written read as whatever the memory holds; there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module elevation_tile_bilinear_lookup
    import etbl_pkg::*;
#(
    parameter int MAX_SIDE      = DEF_MAX_SIDE,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    output logic                        done,
    input  wire logic                   action,
    input  wire logic [20:0]            sample_index,
    input  wire logic [15:0]            sample_word,
    input  wire logic                   last_sample,
    input  wire logic signed [27:0]     query_latitude,
    input  wire logic signed [28:0]     query_longitude,
    output logic signed [23:0]          height_value,
    output logic                        hit,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int FB      = FRACTION_BITS;
    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SW      = $clog2(MAX_SIDE + 1);
    localparam int CW      = 13;                 // cell index incl. the +1 neighbour
    localparam int NW      = 12 + FB;            // dividend: arcsec scaled by 2^FB
    localparam int CNT_W   = $clog2(NW);
    localparam int AW      = 16 + FB;            // multiplier operand A
    localparam int BW      = FB + 1;             // multiplier operand B
    localparam int PW      = AW + BW;

    localparam logic [BW-1:0]    ONE      = BW'(1) << FB;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_DIV,
        S_ADDR,
        S_READ,
        S_CAPT,
        S_MUL
    } state_t;

    state_t             state_reg;
    logic [3:0]         spp_reg;
    logic [10:0]        side_reg;
    logic [7:0]         tile_lat_reg;
    logic [8:0]         tile_lon_reg;
    logic               tile_valid_reg;
    logic [19:0]        frac_lat_reg;
    logic [19:0]        frac_lon_reg;
    logic               coord_reg;
    logic [NW-1:0]      num_reg;
    logic [3:0]         rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NW-1:0]      qy_reg;
    logic [NW-1:0]      qx_reg;
    logic [1:0]         nb_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [15:0]        mem_q_reg;
    logic [15:0]        h_reg [4];
    logic [2:0]         step_reg;
    logic [PW-1:0]      prod_reg;
    logic [PW-1:0]      part_reg;
    logic [AW-1:0]      top_reg;
    logic [AW-1:0]      bot_reg;
    logic               done_reg;
    logic               hit_reg;
    logic [23:0]        height_reg;

    logic [15:0]        mem [DEPTH];

    // Effective settings: zero seconds per pixel acts as one, side is clamped.
    logic [3:0]         spp_eff;
    logic [SW-1:0]      side_eff;
    logic [SW-1:0]      side_m1;

    always_comb
    begin
        spp_eff = (spp_reg == 4'd0) ? 4'd1 : spp_reg;
        if (side_reg < 11'd2)
            side_eff = SW'(2);
        else if (32'(side_reg) > MAX_SIDE)
            side_eff = SW'(MAX_SIDE);
        else
            side_eff = SW'(side_reg);
        side_m1 = side_eff - SW'(1);
    end

    logic accept;
    logic query_hit;

    assign accept    = start && !busy;
    assign query_hit = tile_valid_reg
                       && (query_latitude[27:20] == tile_lat_reg)
                       && (query_longitude[28:20] == tile_lon_reg);

    // Dividend: fraction of a degree in arcseconds, scaled so that the quotient
    // holds the cell index above FB fraction bits.
    logic [19:0]        frac_sel;
    logic [31:0]        arcsec_q20;
    logic [31+FB:0]     scaled;
    logic [NW-1:0]      dividend;

    always_comb
    begin
        frac_sel   = coord_reg ? frac_lon_reg : frac_lat_reg;
        arcsec_q20 = 32'(frac_sel) * 32'(ARCSEC_PER_DEG);
        scaled     = {arcsec_q20, FB'(0)};
        dividend   = NW'(scaled >> 20);
    end

    // Shared restoring divider step: one quotient bit per cycle.
    logic [4:0]         trial;
    logic               trial_ge;
    logic [3:0]         rem_next;
    logic [NW-1:0]      num_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NW-1]};
        trial_ge = trial >= {1'b0, spp_eff};
        rem_next = trial_ge ? 4'(trial - {1'b0, spp_eff}) : trial[3:0];
        num_next = {num_reg[NW-2:0], trial_ge};
    end

    // Neighbour address: rows counted from the bottom, clamped at the edge.
    logic [CW-1:0]      cell_y;
    logic [CW-1:0]      cell_x;
    logic [CW-1:0]      want_y;
    logic [CW-1:0]      want_x;
    logic [SW-1:0]      row_bottom;
    logic [SW-1:0]      col;
    logic [SW-1:0]      row_top;
    logic [2*SW-1:0]    addr_full;

    always_comb
    begin
        cell_y = CW'(qy_reg[NW-1:FB]);
        cell_x = CW'(qx_reg[NW-1:FB]);
        want_y = nb_reg[1] ? cell_y : cell_y + CW'(1);
        want_x = nb_reg[0] ? cell_x + CW'(1) : cell_x;
        row_bottom = (want_y > CW'(side_m1)) ? side_m1 : SW'(want_y);
        col        = (want_x > CW'(side_m1)) ? side_m1 : SW'(want_x);
        row_top    = side_m1 - row_bottom;
        addr_full  = (2*SW)'(row_top) * (2*SW)'(side_eff) + (2*SW)'(col);
    end

    // Shared multiplier operands for the six interpolation products.
    logic [FB-1:0]      dx;
    logic [FB-1:0]      dy;
    logic [AW-1:0]      mul_a;
    logic [BW-1:0]      mul_b;

    always_comb
    begin
        dx = qx_reg[FB-1:0];
        dy = qy_reg[FB-1:0];
        case (step_reg)
            3'd0:
            begin
                mul_a = AW'(h_reg[0]);
                mul_b = ONE - BW'(dx);
            end
            3'd1:
            begin
                mul_a = AW'(h_reg[1]);
                mul_b = BW'(dx);
            end
            3'd2:
            begin
                mul_a = AW'(h_reg[2]);
                mul_b = ONE - BW'(dx);
            end
            3'd3:
            begin
                mul_a = AW'(h_reg[3]);
                mul_b = BW'(dx);
            end
            3'd4:
            begin
                mul_a = top_reg;
                mul_b = BW'(dy);
            end
            3'd5:
            begin
                mul_a = bot_reg;
                mul_b = ONE - BW'(dy);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic [PW-1:0] sum_final;
    logic [23:0]   q8;

    always_comb
    begin
        sum_final = part_reg + prod_reg;
        q8        = sum_final[2*FB+15:2*FB-8];
    end

    // Sample memory: one write port for loads, one registered read port.
    logic [31:0] load_index;

    assign load_index = 32'(sample_index);

    always_ff @(posedge clk)
    begin
        if (accept && !action && load_index < 32'(DEPTH))
        begin
            mem[load_index[ADDR_W-1:0]] <= (sample_word == VOID_WORD) ? 16'd0 : sample_word;
        end
        if (state_reg == S_READ)
        begin
            mem_q_reg <= mem[addr_reg];
        end
    end

    // Data path registers without reset.
    always_ff @(posedge clk)
    begin
        if (accept && action)
        begin
            frac_lat_reg <= query_latitude[19:0];
            frac_lon_reg <= query_longitude[19:0];
        end
        if (state_reg == S_ADDR)
        begin
            addr_reg <= addr_full[ADDR_W-1:0];
        end
        if (state_reg == S_CAPT)
        begin
            h_reg[nb_reg] <= mem_q_reg ^ VOID_WORD;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
            case (step_reg)
                3'd1, 3'd3, 3'd5: part_reg <= prod_reg;
                3'd2:             top_reg  <= AW'(part_reg + prod_reg);
                3'd4:             bot_reg  <= AW'(part_reg + prod_reg);
                default:          ;
            endcase
        end
    end

    // Sequencer, configuration and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            spp_reg        <= SPP_RESET;
            side_reg       <= SIDE_RESET;
            tile_lat_reg   <= '0;
            tile_lon_reg   <= '0;
            tile_valid_reg <= 1'b0;
            coord_reg      <= 1'b0;
            num_reg        <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            qy_reg         <= '0;
            qx_reg         <= '0;
            nb_reg         <= '0;
            step_reg       <= '0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            height_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SECONDS_PER_PIXEL: spp_reg      <= cfg_data[3:0];
                    REG_SIDE_SAMPLES:      side_reg     <= cfg_data[10:0];
                    REG_TILE_LATITUDE:     tile_lat_reg <= cfg_data[7:0];
                    REG_TILE_LONGITUDE:    tile_lon_reg <= cfg_data[8:0];
                    default:               ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!action)
                        begin
                            tile_valid_reg <= last_sample;
                        end
                        else if (query_hit)
                        begin
                            coord_reg <= 1'b0;
                            state_reg <= S_PROD;
                        end
                        else
                        begin
                            done_reg   <= 1'b1;
                            hit_reg    <= 1'b0;
                            height_reg <= '0;
                        end
                    end
                end
                S_PROD:
                begin
                    num_reg   <= dividend;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST)
                    begin
                        if (!coord_reg)
                        begin
                            qy_reg    <= num_next;
                            coord_reg <= 1'b1;
                            state_reg <= S_PROD;
                        end
                        else
                        begin
                            qx_reg    <= num_next;
                            nb_reg    <= '0;
                            state_reg <= S_ADDR;
                        end
                    end
                end
                S_ADDR:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_CAPT;
                end
                S_CAPT:
                begin
                    nb_reg <= nb_reg + 2'd1;
                    if (nb_reg == 2'd3)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_ADDR;
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6)
                    begin
                        // Remove the 32768 m bias: flip the top bit modulo 2^24.
                        height_reg <= {~q8[23], q8[22:0]};
                        hit_reg    <= 1'b1;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign height_value = height_reg;

endmodule
`default_nettype wire

/* hw/rtl/etbl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// etbl_checker: port-level checks of the elevation tile lookup
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module etbl_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic               hit,
    input wire logic signed [23:0] height_value
);

    // Busy only rises on an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // A result word never shows while a query is still in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // A result follows an accepted word or the end of a busy stretch.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("done without a pending query");

    // A miss reports a zero height.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (height_value == 24'sd0))
        else $error("miss with a nonzero height");

endmodule

bind elevation_tile_bilinear_lookup etbl_checker u_etbl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .height_value (height_value)
);
`default_nettype wire

/* dv/tb_elevation_tile_bilinear_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevation_tile_bilinear_lookup: self-checking bench of the tile lookup
// Loads small tiles or windows of a full tile, then sends directed and random
// load and query words. A local model predicts every query result, and each
// done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_elevation_tile_bilinear_lookup;
    import etbl_pkg::*;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam int unsigned STORE_DEPTH = DEF_MAX_SIDE * DEF_MAX_SIDE;
    localparam longint Q20_ONE = 64'd1 << 20;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic        action;
        logic [20:0] sample_index;
        logic [15:0] sample_word;
        logic        last_sample;
        logic [27:0] query_latitude;
        logic [28:0] query_longitude;
    } tile_word_t;

    typedef struct {
        logic [23:0] height_value;
        logic        hit;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic action = 1'b0;
    logic [20:0] sample_index = '0;
    logic [15:0] sample_word = '0;
    logic last_sample = 1'b0;
    logic signed [27:0] query_latitude = '0;
    logic signed [28:0] query_longitude = '0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic busy, done, hit;
    logic signed [23:0] height_value;

    elevation_tile_bilinear_lookup dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .action(action), .sample_index(sample_index), .sample_word(sample_word),
        .last_sample(last_sample), .query_latitude(query_latitude),
        .query_longitude(query_longitude), .height_value(height_value), .hit(hit),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Register copies, shared by the stimulus side and the predictor; they only
    // change while the block is idle.
    logic [3:0]  spp_reg  = SPP_RESET;
    logic [10:0] side_reg = SIDE_RESET;
    logic signed [7:0] lat_reg = '0;
    logic signed [8:0] lon_reg = '0;

    // Predictor state.
    logic [15:0] model_store [int unsigned];
    logic        model_tile_valid = 1'b0;

    // Stimulus-side view: which entries hold data, and whether the tile will be
    // valid when the queued words have gone through.
    bit          loaded_entry [int unsigned];
    bit          plan_tile_valid = 1'b0;

    tile_word_t      pending_words [$];
    lookup_result_t  expected_results [$];
    tile_word_t      cur_word;
    int              gap_count = 0;
    bit              no_gaps = 1'b0;
    int              errors = 0;

    function automatic int unsigned side_eff();
        if (side_reg < 2) return 2;
        if (side_reg > DEF_MAX_SIDE) return DEF_MAX_SIDE;
        return side_reg;
    endfunction

    function automatic int unsigned window_pos(int unsigned row_up, int unsigned col);
        int unsigned s;
        s = side_eff();
        if (row_up > s - 1) row_up = s - 1;
        if (col > s - 1) col = s - 1;
        return (s - 1 - row_up) * s + col;
    endfunction

    // Cell position and fractions of a point given by its Q20 fractional degrees.
    function automatic void locate_cell(input longint unsigned flat, input longint unsigned flon,
                                        output int unsigned pos [4],
                                        output longint unsigned dy, output longint unsigned dx);
        longint unsigned den, plat, plon;
        int unsigned y, x;
        den  = longint'(spp_reg == 0 ? 1 : spp_reg) << 20;
        plat = flat * ARCSEC_PER_DEG;
        plon = flon * ARCSEC_PER_DEG;
        y  = 32'(plat / den);
        x  = 32'(plon / den);
        dy = ((plat % den) << DEF_FRACTION_BITS) / den;
        dx = ((plon % den) << DEF_FRACTION_BITS) / den;
        pos[0] = window_pos(y + 1, x);
        pos[1] = window_pos(y + 1, x + 1);
        pos[2] = window_pos(y, x);
        pos[3] = window_pos(y, x + 1);
    endfunction

    function automatic bit inside_tile(logic signed [27:0] qlat, logic signed [28:0] qlon);
        return ((qlat >>> 20) == lat_reg) && ((qlon >>> 20) == lon_reg);
    endfunction

    // Bilinear height of one accepted query, in Q8 metres.
    function automatic lookup_result_t bilinear_height(tile_word_t w);
        lookup_result_t r;
        int unsigned pos [4];
        longint unsigned dy, dx, one, top, bot, sum, h [4];
        r.height_value = '0;
        r.hit = 1'b0;
        if (!model_tile_valid || !inside_tile(w.query_latitude, w.query_longitude)) return r;
        locate_cell(w.query_latitude[19:0], w.query_longitude[19:0], pos, dy, dx);
        for (int i = 0; i < 4; i++)
            h[i] = (model_store.exists(pos[i]) ? model_store[pos[i]] : 16'h0) ^ VOID_WORD;
        one = 64'd1 << DEF_FRACTION_BITS;
        top = h[0] * (one - dx) + h[1] * dx;
        bot = h[2] * (one - dx) + h[3] * dx;
        sum = top * dy + bot * (one - dy);
        r.height_value = 24'((sum >> (2 * DEF_FRACTION_BITS - 8)) - (64'd32768 << 8));
        r.hit = 1'b1;
        return r;
    endfunction

    // Driver: one word at a time, with a random hold-off after each unless gaps are turned off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (cur_word.action == ACT_LOAD)
                begin
                    if (cur_word.sample_index < STORE_DEPTH)
                        model_store[cur_word.sample_index] =
                            (cur_word.sample_word == VOID_WORD) ? 16'h0 : cur_word.sample_word;
                    model_tile_valid = cur_word.last_sample;
                end
                else
                    expected_results.push_back(bilinear_height(cur_word));
            end
            if (!start || !busy)
            begin
                if (gap_count > 0 || pending_words.size() == 0)
                begin
                    start <= 1'b0;
                    if (gap_count > 0) gap_count <= gap_count - 1;
                end
                else
                begin
                    cur_word = pending_words.pop_front();
                    action          <= cur_word.action;
                    sample_index    <= cur_word.sample_index;
                    sample_word     <= cur_word.sample_word;
                    last_sample     <= cur_word.last_sample;
                    query_latitude  <= cur_word.query_latitude;
                    query_longitude <= cur_word.query_longitude;
                    start <= 1'b1;
                    gap_count <= no_gaps ? 0 : $urandom_range(0, 3);
                end
            end
        end
    end

    // Monitor: every done strobe must match the oldest prediction.
    always @(posedge clk)
    begin
        lookup_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result height %h hit %b", $time, height_value, hit);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (height_value !== e.height_value)
                begin
                    $display("%0t: height expected %h actual %h", $time, e.height_value,
                             height_value);
                    errors++;
                end
                if (hit !== e.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, hit);
                    errors++;
                end
            end
        end
    end

    task automatic push_load(int unsigned idx, logic [15:0] w, logic last);
        tile_word_t t;
        t = '{ACT_LOAD, idx[20:0], w, last, '0, '0};
        if (idx < STORE_DEPTH) loaded_entry[idx] = 1'b1;
        plan_tile_valid = last;
        pending_words.push_back(t);
    endtask

    // A query that would touch an entry never loaded is moved off the tile.
    task automatic push_query(longint qlat, longint qlon);
        tile_word_t t;
        int unsigned pos [4];
        longint unsigned dy, dx;
        t = '{ACT_QUERY, $urandom(), $urandom(), $urandom_range(0, 1), qlat[27:0], qlon[28:0]};
        if (plan_tile_valid && inside_tile(t.query_latitude, t.query_longitude))
        begin
            locate_cell(t.query_latitude[19:0], t.query_longitude[19:0], pos, dy, dx);
            for (int i = 0; i < 4; i++)
                if (!loaded_entry.exists(pos[i]))
                    t.query_longitude =
                        29'((lon_reg == -180 ? lon_reg + 1 : lon_reg - 1) * Q20_ONE);
        end
        pending_words.push_back(t);
    endtask

    task automatic query_in_tile(longint unsigned flat, longint unsigned flon);
        push_query(longint'(lat_reg) * Q20_ONE + flat, longint'(lon_reg) * Q20_ONE + flon);
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_words.size() != 0 || start || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SECONDS_PER_PIXEL: spp_reg  = value[3:0];
            REG_SIDE_SAMPLES:      side_reg = value;
            REG_TILE_LATITUDE:     lat_reg  = value[7:0];
            default:               lon_reg  = value[8:0];
        endcase
    endtask

    // Loads an n by n window at the south-west corner, last mark on the final
    // sample; n equal to the side loads the whole tile.
    task automatic load_window(int unsigned n);
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++)
                push_load(window_pos(r, c), $urandom(), (r == n - 1) && (c == n - 1));
    endtask

    task automatic random_words(int unsigned n, int unsigned win, int unsigned frac_max);
        int unsigned pick;
        for (int unsigned i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (i == n / 2)
            begin
                // The sender holds off until every result is back.
                drain();
            end
            if (pick < 62)
                query_in_tile($urandom_range(0, frac_max), $urandom_range(0, frac_max));
            else if (pick < 72)
                push_query(longint'($urandom_range(0, 188743680)) - 94371840,
                           longint'($urandom_range(0, 377487360)) - 188743680);
            else if (pick < 92)
                push_load(window_pos($urandom_range(0, win - 1), $urandom_range(0, win - 1)),
                          ($urandom_range(0, 9) == 0) ? VOID_WORD : 16'($urandom()),
                          $urandom_range(0, 7) != 0);
            else
                push_load($urandom_range(STORE_DEPTH, 2097151), $urandom(),
                          $urandom_range(0, 1));
        end
        // Leave the tile valid for the next phase's first queries.
        push_load(window_pos(0, 0), $urandom(), 1'b1);
    endtask

    task automatic run_phase(logic [3:0] spp, logic [10:0] side, logic signed [7:0] lat,
                             logic signed [8:0] lon, int unsigned win, int unsigned frac_max);
        drain();
        write_reg(REG_SECONDS_PER_PIXEL, spp);
        write_reg(REG_SIDE_SAMPLES, side);
        write_reg(REG_TILE_LATITUDE, 11'(lat));
        write_reg(REG_TILE_LONGITUDE, 11'(lon));
        if (win > side_eff()) win = side_eff();
        load_window(win);
        no_gaps = ~no_gaps;
        random_words(200, win, frac_max);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the first query comes before any load and must miss.
        query_in_tile(0, 0);
        load_window(4);
        random_words(200, 4, 1700);

        // Directed part on a tile two samples on a side at the far south-west corner.
        drain();
        write_reg(REG_SECONDS_PER_PIXEL, 4'd1);
        write_reg(REG_SIDE_SAMPLES, 11'd2);
        write_reg(REG_TILE_LATITUDE, -11'sd90);
        write_reg(REG_TILE_LONGITUDE, -11'sd180);
        push_load(window_pos(0, 0), VOID_WORD, 1'b0);
        query_in_tile(0, 0);                     // tile not valid yet
        push_load(window_pos(0, 1), 16'h7FFF, 1'b0);
        push_load(window_pos(1, 0), 16'h0000, 1'b0);
        push_load(window_pos(1, 1), 16'hFFFF, 1'b1);
        push_load(STORE_DEPTH, 16'h1234, 1'b1);  // beyond the store, still sets valid
        query_in_tile(0, 0);
        query_in_tile(20'hFFFFF, 20'hFFFFF);     // far corner, neighbours clamped
        query_in_tile(20'hFFFFF, 0);
        query_in_tile(0, 20'hFFFFF);
        query_in_tile(20'h80000, 20'h40000);
        push_query(-64'sd94371840, -64'sd188743680);
        push_query(64'sd94371840, 64'sd188743680);
        push_query(-64'sd91 * Q20_ONE, -64'sd180 * Q20_ONE);
        push_query(-64'sd90 * Q20_ONE, -64'sd179 * Q20_ONE);
        push_load(2097151, 16'h8000, 1'b0);      // invalidates the tile
        query_in_tile(0, 0);
        push_load(window_pos(0, 0), 16'h8001, 1'b1);
        query_in_tile(12345, 678901);
        random_words(200, 2, 20'hFFFFF);

        run_phase(4'd15, 11'd1201, 8'sd89, 9'sd179, 4, 8000);
        run_phase(4'd0, 11'd0, 8'sd45, -9'sd1, 2, 20'hFFFFF);
        run_phase(4'd7, 11'd5, -8'sd1, 9'sd100, 5, 20'hFFFFF);
        run_phase(4'd2, 11'd2047, 8'sd12, 9'sd0, 4, 1000);
        run_phase(4'd1, 11'd11, 8'sd0, -9'sd1, 11, 20'hFFFFF);

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
